### sv/nps_pkg.sv
// shared types and constants of the priority scheduler
package nps_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int ARR_W    = 16;
  localparam int BUR_W    = 16;
  localparam int PRI_W    = 8;
  localparam int TIME_W   = 21;
  localparam int JOB_ID_W = 5;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // candidate handed along the chain
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [ARR_W-1:0]  arrival;
    logic [BUR_W-1:0]  burst;
    logic [PRI_W-1:0]  prio;
    logic              min_valid;
    logic [ARR_W-1:0]  min_arrival;
  } cand_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              load;
    logic [IDX_W-1:0]  load_idx;
    logic [ARR_W-1:0]  arrival;
    logic [BUR_W-1:0]  burst;
    logic [PRI_W-1:0]  prio;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] now;
    logic              clr_done;
    logic              set_done;
    logic [IDX_W-1:0]  done_idx;
  } ctl_t;

  localparam cand_t CAND_NONE = '0;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

### sv/nonpreemptive_priority_scheduler_core.sv
// non-preemptive priority scheduler: chain of job cells and dispatch sequencer
//
// usage: pulse start with in_kind low to load one job (arrival, burst,
// priority); the next edge stores it and busy stays low, so loads may come
// every cycle. a load beyond MAX_JOBS jobs is dropped. start with in_kind high
// runs the schedule over all loaded jobs; busy is high for the whole run.
// each dispatch takes one scan for the best candidate to ripple
// through the cell chain, plus one more scan when the clock has to jump to
// the next arrival. one result per job appears on the out_ ports for a single
// cycle with out_strobe high; out_last_job marks the final one, in the same
// cycle busy falls and the job table is empty again. a run with no jobs
// gives no result. the receiver cannot stall: results are never held back.
// reset (rst_n low at a clock edge) empties the table and clears the run.
module nonpreemptive_priority_scheduler_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [nps_pkg::ARR_W-1:0]     in_arrival_time,
  input  logic [nps_pkg::BUR_W-1:0]     in_burst_length,
  input  logic [nps_pkg::PRI_W-1:0]     in_job_priority,
  output logic                          out_strobe,
  output logic [nps_pkg::JOB_ID_W-1:0]  out_job_id,
  output logic [nps_pkg::TIME_W-1:0]    out_finish_tick,
  output logic [nps_pkg::TIME_W-1:0]    out_turnaround,
  output logic [nps_pkg::TIME_W-1:0]    out_wait_ticks,
  output logic [nps_pkg::BUR_W-1:0]     out_job_energy_halves,
  output logic [nps_pkg::TIME_W-1:0]    out_total_energy_halves,
  output logic                          out_last_job
);

  nps_pkg::state_t             state_r, state_nxt;
  logic [nps_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [nps_pkg::CNT_W-1:0]   scan_r, scan_nxt;
  logic [nps_pkg::CNT_W-1:0]   done_cnt_r, done_cnt_nxt;
  logic [nps_pkg::TIME_W-1:0]  clock_r, clock_nxt;
  logic [nps_pkg::TIME_W-1:0]  energy_r, energy_nxt;
  logic                        strobe_r, strobe_nxt;
  logic [nps_pkg::JOB_ID_W-1:0] id_r, id_nxt;
  logic [nps_pkg::TIME_W-1:0]  comp_r, comp_nxt;
  logic [nps_pkg::TIME_W-1:0]  tat_r, tat_nxt;
  logic [nps_pkg::TIME_W-1:0]  wait_r, wait_nxt;
  logic [nps_pkg::BUR_W-1:0]   bur_r, bur_nxt;
  logic                        last_r, last_nxt;

  nps_pkg::ctl_t               ctl;
  nps_pkg::cand_t              chain [nps_pkg::MAX_JOBS];
  nps_pkg::cand_t              tail;
  logic                        accept;
  logic                        scan_end;
  logic                        is_last;
  logic [nps_pkg::TIME_W-1:0]  bur_ext;
  logic [nps_pkg::TIME_W-1:0]  arr_ext;

  assign busy     = (state_r != nps_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign tail     = chain[nps_pkg::MAX_JOBS-1];
  assign scan_end = (state_r == nps_pkg::ST_SCAN) &&
                    (scan_r == nps_pkg::CNT_W'(nps_pkg::MAX_JOBS));
  assign is_last  = ({1'b0, done_cnt_r} + 1'b1) == {1'b0, count_r};
  assign bur_ext  = {{(nps_pkg::TIME_W-nps_pkg::BUR_W){1'b0}}, tail.burst};
  assign arr_ext  = {{(nps_pkg::TIME_W-nps_pkg::ARR_W){1'b0}}, tail.arrival};

  genvar gi;
  generate
    for (gi = 0; gi < nps_pkg::MAX_JOBS; gi++) begin : g_cell
      nps_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .my_idx   (nps_pkg::IDX_W'(gi)),
        .ctl      (ctl),
        .cand_in  ((gi == 0) ? nps_pkg::CAND_NONE : chain[(gi == 0) ? 0 : gi-1]),
        .cand_out (chain[gi])
      );
    end
  endgenerate

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    scan_nxt     = scan_r;
    done_cnt_nxt = done_cnt_r;
    clock_nxt    = clock_r;
    energy_nxt   = energy_r;
    strobe_nxt   = 1'b0;
    id_nxt       = id_r;
    comp_nxt     = comp_r;
    tat_nxt      = tat_r;
    wait_nxt     = wait_r;
    bur_nxt      = bur_r;
    last_nxt     = last_r;

    ctl          = '0;
    ctl.load_idx = count_r[nps_pkg::IDX_W-1:0];
    ctl.arrival  = in_arrival_time;
    ctl.burst    = in_burst_length;
    ctl.prio     = in_job_priority;
    ctl.count    = count_r;
    ctl.now      = clock_r;
    ctl.done_idx = tail.idx;

    case (state_r)
      nps_pkg::ST_IDLE: begin
        if (accept && in_kind == nps_pkg::KIND_LOAD) begin
          if (count_r < nps_pkg::CNT_W'(nps_pkg::MAX_JOBS)) begin
            ctl.load  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end else if (accept && in_kind == nps_pkg::KIND_RUN) begin
          clock_nxt  = '0;
          energy_nxt = '0;
          ctl.clr_done = 1'b1;
          if (count_r != '0) begin
            done_cnt_nxt = '0;
            scan_nxt     = '0;
            state_nxt    = nps_pkg::ST_SCAN;
          end
        end
      end
      nps_pkg::ST_SCAN: begin
        if (!scan_end) begin
          scan_nxt = scan_r + 1'b1;
        end else if (tail.found) begin
          ctl.set_done = 1'b1;
          clock_nxt    = clock_r + bur_ext;
          energy_nxt   = energy_r + bur_ext;
          strobe_nxt   = 1'b1;
          id_nxt       = nps_pkg::JOB_ID_W'({1'b0, tail.idx} + 1'b1);
          comp_nxt     = clock_r + bur_ext;
          tat_nxt      = clock_r + bur_ext - arr_ext;
          wait_nxt     = clock_r - arr_ext;
          bur_nxt      = tail.burst;
          last_nxt     = is_last;
          done_cnt_nxt = done_cnt_r + 1'b1;
          scan_nxt     = '0;
          if (is_last) begin
            ctl.clr_done = 1'b1;
            ctl.set_done = 1'b0;
            count_nxt    = '0;
            clock_nxt    = '0;
            state_nxt    = nps_pkg::ST_IDLE;
          end
        end else begin
          clock_nxt = {{(nps_pkg::TIME_W-nps_pkg::ARR_W){1'b0}}, tail.min_arrival};
          scan_nxt  = '0;
        end
      end
      default: begin
        state_nxt = nps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= nps_pkg::ST_IDLE;
      count_r    <= '0;
      scan_r     <= '0;
      done_cnt_r <= '0;
      clock_r    <= '0;
      energy_r   <= '0;
      strobe_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      scan_r     <= scan_nxt;
      done_cnt_r <= done_cnt_nxt;
      clock_r    <= clock_nxt;
      energy_r   <= energy_nxt;
      strobe_r   <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    comp_r <= comp_nxt;
    tat_r  <= tat_nxt;
    wait_r <= wait_nxt;
    bur_r  <= bur_nxt;
    last_r <= last_nxt;
  end

  assign out_strobe              = strobe_r;
  assign out_job_id              = id_r;
  assign out_finish_tick         = comp_r;
  assign out_turnaround          = tat_r;
  assign out_wait_ticks          = wait_r;
  assign out_job_energy_halves   = bur_r;
  assign out_total_energy_halves = energy_r;
  assign out_last_job            = last_r;

endmodule

### sv/nps_cell.sv
// one job slot that merges its job into the candidate passing by
module nps_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [nps_pkg::IDX_W-1:0]  my_idx,
  input  nps_pkg::ctl_t              ctl,
  input  nps_pkg::cand_t             cand_in,
  output nps_pkg::cand_t             cand_out
);

  logic [nps_pkg::ARR_W-1:0] arrival_r;
  logic [nps_pkg::BUR_W-1:0] burst_r;
  logic [nps_pkg::PRI_W-1:0] prio_r;
  logic                      done_r;
  logic                      done_nxt;
  logic                      live;
  logic                      ready;
  logic                      better;
  logic                      lower_min;
  nps_pkg::cand_t            cand_r;
  nps_pkg::cand_t            cand_nxt;

  always_ff @(posedge clk) begin
    if (ctl.load && ctl.load_idx == my_idx) begin
      arrival_r <= ctl.arrival;
      burst_r   <= ctl.burst;
      prio_r    <= ctl.prio;
    end
  end

  always_comb begin
    done_nxt = done_r;
    if (ctl.clr_done) begin
      done_nxt = 1'b0;
    end else if (ctl.set_done && ctl.done_idx == my_idx) begin
      done_nxt = 1'b1;
    end
  end

  assign live  = ({1'b0, my_idx} < ctl.count) && !done_r;
  assign ready = live && ({{(nps_pkg::TIME_W-nps_pkg::ARR_W){1'b0}}, arrival_r} <= ctl.now);
  assign better = ready && (!cand_in.found || prio_r < cand_in.prio ||
                  (prio_r == cand_in.prio && arrival_r < cand_in.arrival));
  assign lower_min = live && (!cand_in.min_valid || arrival_r < cand_in.min_arrival);

  always_comb begin
    cand_nxt = cand_in;
    if (better) begin
      cand_nxt.found   = 1'b1;
      cand_nxt.idx     = my_idx;
      cand_nxt.arrival = arrival_r;
      cand_nxt.burst   = burst_r;
      cand_nxt.prio    = prio_r;
    end
    if (lower_min) begin
      cand_nxt.min_valid   = 1'b1;
      cand_nxt.min_arrival = arrival_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
      cand_r <= nps_pkg::CAND_NONE;
    end else begin
      done_r <= done_nxt;
      cand_r <= cand_nxt;
    end
  end

  assign cand_out = cand_r;

endmodule

### sv/nps_checker.sv
// port checks for the priority scheduler and their binding
module nps_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          in_kind,
  input logic                          out_strobe,
  input logic [nps_pkg::JOB_ID_W-1:0]  out_job_id,
  input logic                          out_last_job
);

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results too close together");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last_job |-> busy)
    else $error("run ended before last item");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last_job |-> !busy)
    else $error("still busy after last item");

  a_id_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_job_id != '0)
    else $error("job id zero");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_kind == nps_pkg::KIND_LOAD |=> !busy)
    else $error("load made block busy");

endmodule

bind nonpreemptive_priority_scheduler_core nps_checker u_nps_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_kind      (in_kind),
  .out_strobe   (out_strobe),
  .out_job_id   (out_job_id),
  .out_last_job (out_last_job)
);

### dv/nps_sched_checker.sv
// checker for the priority scheduler: predicts dispatch order and compares results
module nps_sched_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_kind,
  input  logic [nps_pkg::ARR_W-1:0]     in_arrival_time,
  input  logic [nps_pkg::BUR_W-1:0]     in_burst_length,
  input  logic [nps_pkg::PRI_W-1:0]     in_job_priority,
  input  logic                          out_strobe,
  input  logic [nps_pkg::JOB_ID_W-1:0]  out_job_id,
  input  logic [nps_pkg::TIME_W-1:0]    out_finish_tick,
  input  logic [nps_pkg::TIME_W-1:0]    out_turnaround,
  input  logic [nps_pkg::TIME_W-1:0]    out_wait_ticks,
  input  logic [nps_pkg::BUR_W-1:0]     out_job_energy_halves,
  input  logic [nps_pkg::TIME_W-1:0]    out_total_energy_halves,
  input  logic                          out_last_job,
  output int                            fail_count,
  output int                            pending
);
  import nps_pkg::*;

  typedef struct {
    logic [JOB_ID_W-1:0] job_id;
    logic [TIME_W-1:0]   completion;
    logic [TIME_W-1:0]   turnaround;
    logic [TIME_W-1:0]   waiting;
    logic [BUR_W-1:0]    energy;
    logic [TIME_W-1:0]   energy_total;
    logic                last;
  } dispatch_t;

  dispatch_t        dispatch_q[$];
  logic [ARR_W-1:0] job_arrival[MAX_JOBS];
  logic [BUR_W-1:0] job_burst[MAX_JOBS];
  logic [PRI_W-1:0] job_prio[MAX_JOBS];
  int               jobs_loaded;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // replay non-preemptive dispatch over the loaded table
  task automatic predict_dispatch();
    bit        finished[MAX_JOBS];
    longint    clock_now, energy_sum, turn;
    int        best, k, i;
    dispatch_t d;
    clock_now = 0;
    energy_sum = 0;
    for (i = 0; i < MAX_JOBS; i++) finished[i] = 0;
    for (k = 0; k < jobs_loaded; k++) begin
      best = -1;
      for (i = 0; i < jobs_loaded; i++)
        if (!finished[i] && job_arrival[i] <= clock_now)
          if (best < 0 || job_prio[i] < job_prio[best] ||
              (job_prio[i] == job_prio[best] && job_arrival[i] < job_arrival[best]))
            best = i;
      if (best < 0) begin
        // nothing ready: jump to the next arrival
        clock_now = 64'h7fffffffffffffff;
        for (i = 0; i < jobs_loaded; i++)
          if (!finished[i] && job_arrival[i] < clock_now) clock_now = job_arrival[i];
        for (i = 0; i < jobs_loaded; i++)
          if (!finished[i] && job_arrival[i] <= clock_now)
            if (best < 0 || job_prio[i] < job_prio[best] ||
                (job_prio[i] == job_prio[best] && job_arrival[i] < job_arrival[best]))
              best = i;
      end
      clock_now += job_burst[best];
      energy_sum += job_burst[best];
      turn = clock_now - job_arrival[best];
      finished[best] = 1;
      d.job_id       = JOB_ID_W'(best + 1);
      d.completion   = TIME_W'(clock_now);
      d.turnaround   = TIME_W'(turn);
      d.waiting      = TIME_W'(turn - job_burst[best]);
      d.energy       = job_burst[best];
      d.energy_total = TIME_W'(energy_sum);
      d.last         = (k + 1 == jobs_loaded);
      dispatch_q.insert(dispatch_q.size(), d);
    end
    jobs_loaded = 0;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    jobs_loaded = 0;
  end

  always @(posedge clk) begin
    dispatch_t d;
    if (!rst_n) begin
      jobs_loaded = 0;
      dispatch_q.delete();
    end else begin
      if (start && !busy) begin
        if (in_kind == KIND_LOAD) begin
          if (jobs_loaded < MAX_JOBS) begin
            job_arrival[jobs_loaded] = in_arrival_time;
            job_burst[jobs_loaded]   = in_burst_length;
            job_prio[jobs_loaded]    = in_job_priority;
            jobs_loaded++;
          end
        end else begin
          predict_dispatch();
        end
      end
      if (out_strobe) begin
        if (dispatch_q.size() == 0) begin
          report_mismatch("unexpected result, job_id", out_job_id, 0);
        end else begin
          d = dispatch_q.pop_front();
          if (out_job_id !== d.job_id)
            report_mismatch("job_id", out_job_id, d.job_id);
          if (out_finish_tick !== d.completion)
            report_mismatch("finish_tick", out_finish_tick, d.completion);
          if (out_turnaround !== d.turnaround)
            report_mismatch("turnaround", out_turnaround, d.turnaround);
          if (out_wait_ticks !== d.waiting)
            report_mismatch("wait_ticks", out_wait_ticks, d.waiting);
          if (out_job_energy_halves !== d.energy)
            report_mismatch("job_energy_halves", out_job_energy_halves, d.energy);
          if (out_total_energy_halves !== d.energy_total)
            report_mismatch("total_energy_halves", out_total_energy_halves,
                            d.energy_total);
          if (out_last_job !== d.last)
            report_mismatch("last_job", out_last_job, d.last);
        end
      end
    end
    pending = dispatch_q.size();
  end

endmodule

### dv/tb_nonpreemptive_priority_scheduler_core.sv
// testbench top for the priority scheduler: stimulus, reset and verdict
module tb_nonpreemptive_priority_scheduler_core;
  import nps_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_kind;
  logic [ARR_W-1:0]    in_arrival_time;
  logic [BUR_W-1:0]    in_burst_length;
  logic [PRI_W-1:0]    in_job_priority;
  logic                out_strobe;
  logic [JOB_ID_W-1:0] out_job_id;
  logic [TIME_W-1:0]   out_finish_tick;
  logic [TIME_W-1:0]   out_turnaround;
  logic [TIME_W-1:0]   out_wait_ticks;
  logic [BUR_W-1:0]    out_job_energy_halves;
  logic [TIME_W-1:0]   out_total_energy_halves;
  logic                out_last_job;
  int                  fail_count;
  int                  pending;
  int                  cycle_count;
  int                  items_sent;
  bit                  idle_allowed;

  nonpreemptive_priority_scheduler_core dut (.*);

  nps_sched_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("tb_nonpreemptive_priority_scheduler_core: FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(logic kind, logic [ARR_W-1:0] arr, logic [BUR_W-1:0] bur,
                           logic [PRI_W-1:0] pri);
    bit taken;
    if (idle_allowed && $urandom_range(99) < 15) begin
      start <= 0;
      @(posedge clk);
    end
    start           <= 1;
    in_kind         <= kind;
    in_arrival_time <= arr;
    in_burst_length <= bur;
    in_job_priority <= pri;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic wait_drained();
    start <= 0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic send_random_job(int shape);
    logic [ARR_W-1:0] arr;
    logic [BUR_W-1:0] bur;
    logic [PRI_W-1:0] pri;
    arr = (shape == 0) ? ARR_W'($urandom_range(0, 40)) : ARR_W'($urandom);
    bur = ($urandom_range(3) == 0) ? BUR_W'($urandom) : BUR_W'($urandom_range(0, 30));
    pri = ($urandom_range(1) == 0) ? PRI_W'($urandom_range(0, 3)) : PRI_W'($urandom);
    send_item(KIND_LOAD, arr, bur, pri);
  endtask

  initial begin
    int n_jobs;
    rst_n = 0;
    start = 0;
    in_kind = KIND_LOAD;
    in_arrival_time = '0;
    in_burst_length = '0;
    in_job_priority = '0;
    items_sent = 0;
    idle_allowed = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // empty table run
    send_item(KIND_RUN, '1, '1, '1);
    // extremes and zero burst
    send_item(KIND_LOAD, 16'hffff, 16'hffff, 8'hff);
    send_item(KIND_LOAD, 16'd0, 16'd0, 8'd0);
    send_item(KIND_LOAD, 16'hffff, 16'd0, 8'h00);
    send_item(KIND_LOAD, 16'd5, 16'hffff, 8'hff);
    send_item(KIND_RUN, 16'd0, 16'd0, 8'd0);
    // equal priorities, arrival then id order, and a gap before the first job
    send_item(KIND_LOAD, 16'd30, 16'd4, 8'd7);
    send_item(KIND_LOAD, 16'd20, 16'd4, 8'd7);
    send_item(KIND_LOAD, 16'd20, 16'd2, 8'd7);
    send_item(KIND_LOAD, 16'd100, 16'd1, 8'd0);
    send_item(KIND_RUN, 16'd0, 16'd0, 8'd0);
    wait_drained();

    idle_allowed = 1;
    while (items_sent < 320) begin
      if (items_sent > 130 && items_sent < 210) idle_allowed = 0;
      else idle_allowed = 1;
      case ($urandom_range(9))
        0: n_jobs = $urandom_range(17, 20);
        1: n_jobs = 16;
        2: n_jobs = $urandom_range(0, 1);
        default: n_jobs = $urandom_range(2, 10);
      endcase
      begin
        int shape;
        shape = $urandom_range(2) == 0;
        repeat (n_jobs) send_random_job(shape);
      end
      if ($urandom_range(7) == 0) wait_drained();
      send_item(KIND_RUN, ARR_W'($urandom), BUR_W'($urandom), PRI_W'($urandom));
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_nonpreemptive_priority_scheduler_core: PASS");
    end else begin
      $display("tb_nonpreemptive_priority_scheduler_core: FAIL");
    end
    $finish;
  end

endmodule

### files.f
sv/nps_pkg.sv
sv/nps_cell.sv
sv/nonpreemptive_priority_scheduler_core.sv
sv/nps_checker.sv
dv/nps_sched_checker.sv
dv/tb_nonpreemptive_priority_scheduler_core.sv
